// ===== sv/cle_pkg.sv =====
// Shared types and constants of the console line editor.
// Control character codes, item commands, result status codes and the line store write port; no dependencies.
package cle_pkg;

  // Control characters recognized on the receive side
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_EOF  = 8'h04;  // ctrl-D
  localparam logic [7:0] CH_BS   = 8'h08;  // ctrl-H
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_DUMP = 8'h10;  // ctrl-P
  localparam logic [7:0] CH_KILL = 8'h15;  // ctrl-U
  localparam logic [7:0] CH_DEL  = 8'h7F;

  // Item commands
  typedef enum logic {
    CMD_RECEIVE = 1'b0,
    CMD_READ    = 1'b1
  } command_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STORED   = 3'd0,
    ST_ERASED   = 3'd1,
    ST_IGNORED  = 3'd2,
    ST_DUMP     = 3'd3,
    ST_READ     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_EOF_USED = 3'd6,
    ST_EOF_KEPT = 3'd7
  } status_e;

  // Write port of the line store
  typedef struct packed {
    logic       en;
    logic [7:0] data;
  } store_wr_t;

endpackage

// ===== sv/cle_if.sv =====
// Valid/ready channel interfaces of the console line editor.
// Item channel carries commands in, result channel carries results out; no dependencies.
interface cle_item_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_char;
  logic       read_first;

  modport source (output valid, command, rx_char, read_first, input ready);
  modport sink   (input valid, command, rx_char, read_first, output ready);
endinterface

interface cle_result_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic [7:0] erase_count;
  logic       line_ready;
  logic [7:0] read_byte;
  logic       line_end;

  modport source (output valid, status, echo_valid, echo_char, erase_count, line_ready,
                  read_byte, line_end, input ready);
  modport sink   (input valid, status, echo_valid, echo_char, erase_count, line_ready,
                  read_byte, line_end, output ready);
endinterface

// ===== sv/cle_line_store.sv =====
// Line store of the console line editor: byte ring memory with a registered head byte.
// Depends on cle_pkg for the write port struct.
module cle_line_store import cle_pkg::*; #(
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  store_wr_t                wr_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [7:0]               head_o
);

  localparam int ADDR_W = $clog2(DEPTH);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] head_q;

  // Store typed bytes
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_addr_i] <= wr_i.data;
    end
  end

  // Fetch the byte at the next read position; forward a same-cycle write to it
  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_addr_i == rd_addr_i)) begin
      head_q <= wr_i.data;
    end else begin
      head_q <= mem_q[rd_addr_i[ADDR_W-1:0]];
    end
  end

  assign head_o = head_q;

endmodule

// ===== sv/console_line_editor.sv =====
// Console line editor: canonical line-at-a-time console input over a byte ring buffer.
// Depends on cle_pkg, cle_item_if / cle_result_if and cle_line_store.
//
// The block accepts one item per clock cycle, receive and read items mixed freely, and
// delivers each result through the input register and one pass of index and character
// logic into the result register. The read side keeps the byte at the read index
// prefetched from the line store's registered read port, so a read pops it without
// waiting on the memory. Results come out in item order, one per item; the item channel
// stalls only while the result register holds a beat that is not taken. Erase echo is
// reported as a count of backspace-space-backspace sequences, saturating at 255.
module console_line_editor import cle_pkg::*; #(
  parameter int BUF_DEPTH = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cle_item_if.sink     item_i,
  cle_result_if.source result_o
);

  localparam int IDX_W  = $clog2(2 * BUF_DEPTH);
  localparam int SLOT_W = $clog2(BUF_DEPTH);
  localparam int CNT_W  = (IDX_W > 8) ? IDX_W : 8;
  localparam logic [IDX_W-1:0] IDX_DEPTH = IDX_W'(BUF_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(2 * BUF_DEPTH - 1);

  // Index arithmetic modulo twice the depth
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
    return (a == IDX_LAST) ? '0 : a + IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] a);
    return (a == '0) ? IDX_LAST : a - IDX_W'(1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dist(input logic [IDX_W-1:0] hi,
                                                input logic [IDX_W-1:0] lo);
    logic [IDX_W:0] wrapped;
    wrapped = {1'b0, hi} + (IDX_W+1)'(2 * BUF_DEPTH) - {1'b0, lo};
    return (hi >= lo) ? (hi - lo) : wrapped[IDX_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] idx_slot(input logic [IDX_W-1:0] a);
    logic [IDX_W-1:0] s;
    s = (a >= IDX_DEPTH) ? (a - IDX_DEPTH) : a;
    return s[SLOT_W-1:0];
  endfunction

  // Handshake and stage control
  logic s1_vq, s1_vd;
  logic out_vq, out_vd;
  logic out_take, s1_fire, in_acc;

  // Input register
  logic       cmd_q;
  logic [7:0] rx_q;
  logic       first_q;

  // Indices
  logic [IDX_W-1:0] read_q, read_d;
  logic [IDX_W-1:0] commit_q, commit_d;
  logic [IDX_W-1:0] edit_q, edit_d;

  // Result register
  status_e    status_q, status_d;
  logic       echo_v_q, echo_v_d;
  logic [7:0] echo_c_q, echo_c_d;
  logic [7:0] erase_q, erase_d;
  logic       lready_q, lready_d;
  logic [7:0] rbyte_q, rbyte_d;
  logic       lend_q, lend_d;

  // Line store access
  store_wr_t   wr;
  logic [7:0]  head;

  logic [IDX_W-1:0] dist_er, dist_ec, edit_inc;
  logic [CNT_W-1:0] kill_cnt;
  logic [7:0]       stored_c;

  assign out_take     = !out_vq || result_o.ready;
  assign s1_fire      = s1_vq && out_take;
  assign item_i.ready = !s1_vq || out_take;
  assign in_acc       = item_i.valid && item_i.ready;

  always_comb begin
    s1_vd = s1_vq;
    if (in_acc) begin
      s1_vd = 1'b1;
    end else if (s1_fire) begin
      s1_vd = 1'b0;
    end
    out_vd = out_vq;
    if (s1_fire) begin
      out_vd = 1'b1;
    end else if (result_o.ready) begin
      out_vd = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vq    <= 1'b0;
      out_vq   <= 1'b0;
      read_q   <= '0;
      commit_q <= '0;
      edit_q   <= '0;
    end else begin
      s1_vq    <= s1_vd;
      out_vq   <= out_vd;
      read_q   <= read_d;
      commit_q <= commit_d;
      edit_q   <= edit_d;
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= item_i.command;
      rx_q    <= item_i.rx_char;
      first_q <= item_i.read_first;
    end
  end

  assign dist_er  = idx_dist(edit_q, read_q);
  assign dist_ec  = idx_dist(edit_q, commit_q);
  assign edit_inc = idx_inc(edit_q);
  assign kill_cnt = CNT_W'(dist_ec);
  assign stored_c = (rx_q == CH_CR) ? CH_NL : rx_q;

  // Edit or read one item
  always_comb begin
    read_d   = read_q;
    commit_d = commit_q;
    edit_d   = edit_q;
    status_d = ST_IGNORED;
    echo_v_d = 1'b0;
    echo_c_d = '0;
    erase_d  = '0;
    lready_d = 1'b0;
    rbyte_d  = '0;
    lend_d   = 1'b0;
    wr.en    = 1'b0;
    wr.data  = stored_c;
    if (s1_fire) begin
      if (command_e'(cmd_q) == CMD_RECEIVE) begin
        unique case (rx_q) inside
          CH_DUMP: begin
            status_d = ST_DUMP;
          end
          CH_KILL: begin
            status_d = ST_ERASED;
            edit_d   = commit_q;
            erase_d  = (kill_cnt > CNT_W'(255)) ? 8'hFF : kill_cnt[7:0];
          end
          CH_BS, CH_DEL: begin
            status_d = ST_ERASED;
            if (edit_q != commit_q) begin
              edit_d  = idx_dec(edit_q);
              erase_d = 8'd1;
            end
          end
          default: begin
            if (rx_q == CH_NUL || dist_er >= IDX_DEPTH) begin
              status_d = ST_IGNORED;
            end else begin
              status_d = ST_STORED;
              echo_v_d = 1'b1;
              echo_c_d = stored_c;
              wr.en    = 1'b1;
              edit_d   = edit_inc;
              if (stored_c == CH_NL || stored_c == CH_EOF ||
                  idx_dist(edit_inc, read_q) == IDX_DEPTH) begin
                commit_d = edit_inc;
                lready_d = 1'b1;
              end
            end
          end
        endcase
      end else begin
        if (read_q == commit_q) begin
          status_d = ST_EMPTY;
        end else if (head == CH_EOF) begin
          if (first_q) begin
            read_d   = idx_inc(read_q);
            status_d = ST_EOF_USED;
          end else begin
            status_d = ST_EOF_KEPT;
          end
        end else begin
          read_d   = idx_inc(read_q);
          status_d = ST_READ;
          rbyte_d  = head;
          lend_d   = (head == CH_NL);
        end
      end
    end
  end

  // Hold the result beat until it is taken
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      status_q <= status_d;
      echo_v_q <= echo_v_d;
      echo_c_q <= echo_c_d;
      erase_q  <= erase_d;
      lready_q <= lready_d;
      rbyte_q  <= rbyte_d;
      lend_q   <= lend_d;
    end
  end

  cle_line_store #(
    .DEPTH (BUF_DEPTH)
  ) u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .wr_addr_i (idx_slot(edit_q)),
    .rd_addr_i (idx_slot(read_d)),
    .head_o    (head)
  );

  assign result_o.valid       = out_vq;
  assign result_o.status      = status_q;
  assign result_o.echo_valid  = echo_v_q;
  assign result_o.echo_char   = echo_c_q;
  assign result_o.erase_count = erase_q;
  assign result_o.line_ready  = lready_q;
  assign result_o.read_byte   = rbyte_q;
  assign result_o.line_end    = lend_q;

`ifndef NO_ASSERTIONS
  // Typed text never exceeds the buffer
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dist_er <= IDX_DEPTH)
    else $error("typed text exceeds buffer depth");

  // Commit point lies between read and edit points
  a_commit_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_dist(commit_q, read_q) <= dist_er)
    else $error("commit index outside read..edit range");

  // A committed line comes only from a stored byte
  a_commit_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.line_ready) |-> (status_q == ST_STORED))
    else $error("line ready without stored byte");

  // An empty read leaves the read index in place
  a_empty_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_fire && cmd_q && (read_q == commit_q)) |=> $stable(read_q))
    else $error("read index moved on empty read");
`endif

endmodule
